// File: rtl/core/salc_pkg.sv
`default_nettype none

package salc_pkg;

  // Width of each running total.
  localparam int TALLY_W = 32;

  // Access kinds carried by req_type.
  localparam logic [1:0] REQ_INSTR  = 2'd0;
  localparam logic [1:0] REQ_LOAD   = 2'd1;
  localparam logic [1:0] REQ_STORE  = 2'd2;
  localparam logic [1:0] REQ_MODIFY = 2'd3;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } salc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // take a request beat and read its set row
    logic update;      // resolve the lookup and write the row back
    logic clear_step;  // zero one row of the line store
  } salc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the clearing pass is on its final row
  } salc_status_t;

endpackage

`default_nettype wire

// File: rtl/core/salc_ram.sv
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/salc_ctrl.sv
`default_nettype none

module salc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  output salc_pkg::salc_cmd_t        cmd,
  input  wire salc_pkg::salc_status_t status
);

  import salc_pkg::*;

  salc_state_t state;
  salc_state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/salc_dp.sv
`default_nettype none

module salc_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64,
  parameter int STAMP_BITS   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire salc_pkg::salc_cmd_t      cmd,
  output salc_pkg::salc_status_t        status,
  input  wire logic [2:0]               set_bits,
  input  wire logic [3:0]               ways_in_use,
  input  wire logic [5:0]               block_bits,
  input  wire logic [1:0]               req_type,
  input  wire logic [63:0]              address,
  output logic                          done,
  output logic                          accessed,
  output logic                          hit,
  output logic                          missed,
  output logic                          evicted,
  output logic                          second_hit,
  output logic [salc_pkg::TALLY_W-1:0]  hits_total,
  output logic [salc_pkg::TALLY_W-1:0]  misses_total,
  output logic [salc_pkg::TALLY_W-1:0]  evictions_total
);

  import salc_pkg::*;

  localparam int SETS    = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TREE_N  = 1 << $clog2(MAX_WAYS);
  localparam int LINE_W  = 1 + ADDR_BITS + STAMP_BITS;
  localparam int ROW_W   = MAX_WAYS * LINE_W;

  // Effective set bit count, clamped to the store size.
  logic [3:0]             sb_eff;
  logic [SET_W-1:0]       set_mask;
  logic [ADDR_BITS-1:0]   in_addr;
  logic [ADDR_BITS-1:0]   in_shifted;
  logic [SET_W-1:0]       in_set;

  // Request registers.
  logic [1:0]             req_q;
  logic [ADDR_BITS-1:0]   addr_q;
  logic [SET_W-1:0]       set_q;
  logic [SET_W-1:0]       clr_cnt;

  // Line store.
  logic                   ram_we;
  logic [SET_W-1:0]       ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;
  logic [ROW_W-1:0]       rd_row;
  logic [ROW_W-1:0]       wr_row;

  // Lookup.
  logic [6:0]             tag_shift;
  logic [ADDR_BITS-1:0]   tag_q;
  logic [STAMP_BITS-1:0]  access_stamp;
  logic [STAMP_BITS-1:0]  stamp_new;
  logic                   way_valid [MAX_WAYS];
  logic [ADDR_BITS-1:0]   way_tag   [MAX_WAYS];
  logic [STAMP_BITS-1:0]  way_stamp [MAX_WAYS];
  logic [MAX_WAYS-1:0]    way_elig;
  logic [MAX_WAYS-1:0]    hit_vec;
  logic [MAX_WAYS-1:0]    inv_vec;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       inv_way;
  logic [WAY_W-1:0]       fill_way;
  logic                   acc_now;
  logic                   hit_now;
  logic                   has_inv;
  logic                   second_now;

  // LRU tournament tree, heap-indexed from 1.
  logic                   node_ok    [2*TREE_N];
  logic [STAMP_BITS-1:0]  node_stamp [2*TREE_N];
  logic [WAY_W-1:0]       node_idx   [2*TREE_N];

  // Tallies.
  logic [1:0]             hit_inc;
  logic [TALLY_W:0]       hit_sum;
  logic [TALLY_W:0]       miss_sum;
  logic [TALLY_W:0]       evict_sum;
  logic [TALLY_W-1:0]     hit_tally_next;
  logic [TALLY_W-1:0]     miss_tally_next;
  logic [TALLY_W-1:0]     evict_tally_next;

  // Set index of the incoming beat, used for the row read.
  always_comb begin
    sb_eff = ({1'b0, set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits};
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (4'(i) < sb_eff);
    end
    in_addr    = address[ADDR_BITS-1:0];
    in_shifted = in_addr >> block_bits;
    in_set     = in_shifted[SET_W-1:0] & set_mask;
  end

  // Capture the request beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      addr_q <= in_addr;
      set_q  <= in_set;
    end
  end

  // Row counter for the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clear_last = (clr_cnt == SET_W'(SETS - 1));

  // Unpack the set row and flag the ways in use.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_valid[w] = rd_row[w*LINE_W + LINE_W - 1];
      way_tag[w]   = rd_row[w*LINE_W + STAMP_BITS +: ADDR_BITS];
      way_stamp[w] = rd_row[w*LINE_W +: STAMP_BITS];
      way_elig[w]  = (w == 0) || ({1'b0, ways_in_use} > 5'(w));
    end
  end

  // Tag compare and search for a free way, lowest way first.
  always_comb begin
    tag_shift = {1'b0, block_bits} + {3'b000, sb_eff};
    tag_q     = addr_q >> tag_shift;
    acc_now   = (req_q != REQ_INSTR);
    hit_way   = '0;
    inv_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec[w] = way_elig[w] && way_valid[w] && (way_tag[w] == tag_q);
      inv_vec[w] = way_elig[w] && !way_valid[w];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv_vec[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    hit_now    = acc_now && (|hit_vec);
    has_inv    = |inv_vec;
    second_now = (req_q == REQ_MODIFY);
  end

  // Oldest stamp among the ways in use; a tie keeps the lower way.
  always_comb begin
    for (int n = 0; n < 2*TREE_N; n++) begin
      node_ok[n]    = 1'b0;
      node_stamp[n] = '0;
      node_idx[n]   = '0;
    end
    for (int i = 0; i < TREE_N; i++) begin
      if (i < MAX_WAYS) begin
        node_ok[TREE_N + i]    = way_elig[i];
        node_stamp[TREE_N + i] = way_stamp[i];
        node_idx[TREE_N + i]   = WAY_W'(i);
      end
    end
    for (int n = TREE_N - 1; n >= 1; n--) begin
      if (!node_ok[2*n] ||
          (node_ok[2*n+1] && (node_stamp[2*n+1] < node_stamp[2*n]))) begin
        node_ok[n]    = node_ok[2*n+1];
        node_stamp[n] = node_stamp[2*n+1];
        node_idx[n]   = node_idx[2*n+1];
      end else begin
        node_ok[n]    = node_ok[2*n];
        node_stamp[n] = node_stamp[2*n];
        node_idx[n]   = node_idx[2*n];
      end
    end
  end

  // New row: the touched way gets the tag and the fresh stamp.
  always_comb begin
    stamp_new = access_stamp + 1'b1;
    if (hit_now) begin
      fill_way = hit_way;
    end else if (has_inv) begin
      fill_way = inv_way;
    end else begin
      fill_way = node_idx[1];
    end
    wr_row = rd_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == fill_way) begin
        wr_row[w*LINE_W +: LINE_W] = {1'b1, tag_q, stamp_new};
      end
    end
  end

  // Write port: clearing pass or write-back of the looked-up row.
  always_comb begin
    ram_we    = cmd.clear_step || (cmd.update && acc_now);
    ram_waddr = cmd.clear_step ? clr_cnt : set_q;
    ram_wdata = cmd.clear_step ? '0 : wr_row;
  end

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_set),
    .rdata (rd_row)
  );

  // Saturating totals.
  always_comb begin
    hit_inc          = {1'b0, hit_now} + {1'b0, second_now};
    hit_sum          = {1'b0, hits_total} + (TALLY_W+1)'(hit_inc);
    miss_sum         = {1'b0, misses_total} + (TALLY_W+1)'(acc_now && !hit_now);
    evict_sum        = {1'b0, evictions_total}
                     + (TALLY_W+1)'(acc_now && !hit_now && !has_inv);
    hit_tally_next   = hit_sum[TALLY_W]   ? '1 : hit_sum[TALLY_W-1:0];
    miss_tally_next  = miss_sum[TALLY_W]  ? '1 : miss_sum[TALLY_W-1:0];
    evict_tally_next = evict_sum[TALLY_W] ? '1 : evict_sum[TALLY_W-1:0];
  end

  // Stamp, tallies and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_stamp    <= '0;
      hits_total      <= '0;
      misses_total    <= '0;
      evictions_total <= '0;
      done            <= 1'b0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        access_stamp    <= stamp_new;
        hits_total      <= hit_tally_next;
        misses_total    <= miss_tally_next;
        evictions_total <= evict_tally_next;
      end
    end
  end

  // Per-item result flags.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      accessed   <= acc_now;
      hit        <= hit_now;
      missed     <= acc_now && !hit_now;
      evicted    <= acc_now && !hit_now && !has_inv;
      second_hit <= second_now;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/set_assoc_lru_cache_model.sv
// Channel   Beat marked by         Payload
// -------   --------------------   ------------------------------------------------
// request   start high, busy low   req_type, address
// result    done high, one cycle   accessed, hit, missed, evicted, second_hit, totals
// config    psel, penable, pwrite  paddr, pwdata (APB write, pready always high)
//
// Each request runs in two steps: the set row is read from the line store as the
// beat is taken, and in the next cycle the ways are compared and the row is written
// back. The line store holds each set as a single row, with one read and one write port.
// The result strobe is registered in the cycle after the write-back; a new beat may be taken alongside it.
// After reset the line store is cleared one row a cycle, all 2^MAX_SET_BITS rows
// (64 by default), with busy high. The receiver of results cannot stall.
`default_nettype none

module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 64,
  parameter int STAMP_BITS   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [3:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               req_type,
  input  wire logic [63:0]              address,
  output logic                          done,
  output logic                          accessed,
  output logic                          hit,
  output logic                          missed,
  output logic                          evicted,
  output logic                          second_hit,
  output logic [salc_pkg::TALLY_W-1:0]  hits_total,
  output logic [salc_pkg::TALLY_W-1:0]  misses_total,
  output logic [salc_pkg::TALLY_W-1:0]  evictions_total
);

  import salc_pkg::*;

  logic [2:0]   set_bits;
  logic [3:0]   ways_in_use;
  logic [5:0]   block_bits;
  logic         cfg_write;
  logic [1:0]   reg_idx;
  salc_cmd_t    cmd;
  salc_status_t status;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd4;
      ways_in_use <= 4'd1;
      block_bits  <= 6'd4;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SET_BITS:   set_bits    <= pwdata[2:0];
        REG_WAYS:       ways_in_use <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits  <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_SET_BITS:   prdata = {29'd0, set_bits};
      REG_WAYS:       prdata = {28'd0, ways_in_use};
      REG_BLOCK_BITS: prdata = {26'd0, block_bits};
      default:        prdata = '0;
    endcase
  end

  salc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS),
    .STAMP_BITS   (STAMP_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .set_bits        (set_bits),
    .ways_in_use     (ways_in_use),
    .block_bits      (block_bits),
    .req_type        (req_type),
    .address         (address),
    .done            (done),
    .accessed        (accessed),
    .hit             (hit),
    .missed          (missed),
    .evicted         (evicted),
    .second_hit      (second_hit),
    .hits_total      (hits_total),
    .misses_total    (misses_total),
    .evictions_total (evictions_total)
  );

endmodule

`default_nettype wire

// File: rtl/core/salc_checker.sv
`default_nettype none

module salc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        accessed,
  input wire logic        hit,
  input wire logic        missed,
  input wire logic        evicted,
  input wire logic [31:0] hits_total,
  input wire logic [31:0] misses_total
);

  // A taken request beat yields its result after the update state, once the result register is loaded.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result strobe missing after a request beat");

  // An access is either a hit or a miss, never both.
  a_hit_or_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> ((hit ^ missed) == accessed))
    else $error("hit and miss flags disagree with accessed");

  // Only a miss can evict.
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> missed)
    else $error("eviction reported without a miss");

  // The hit and miss totals never step backwards.
  a_totals_grow: assert property (@(posedge clk) disable iff (rst)
    done |-> ((hits_total >= $past(hits_total)) && (misses_total >= $past(misses_total))))
    else $error("running totals decreased");

endmodule

bind set_assoc_lru_cache_model salc_checker u_salc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .accessed     (accessed),
  .hit          (hit),
  .missed       (missed),
  .evicted      (evicted),
  .hits_total   (hits_total),
  .misses_total (misses_total)
);

`default_nettype wire

// File: test/salc_checker.sv
module salc_scoreboard (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic          pready,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire logic [1:0]    req_type,
  input  wire logic [63:0]   address,
  input  wire logic          done,
  input  wire logic          accessed,
  input  wire logic          hit,
  input  wire logic          missed,
  input  wire logic          evicted,
  input  wire logic          second_hit,
  input  wire logic [31:0]   hits_total,
  input  wire logic [31:0]   misses_total,
  input  wire logic [31:0]   evictions_total,
  output int                 fail_count,
  output int                 pending
);
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_LIMIT = 6;
  localparam int WAY_LIMIT = 8;
  localparam int LINES     = (1 << SET_LIMIT) * WAY_LIMIT;

  typedef struct packed {
    logic        accessed;
    logic        hit;
    logic        missed;
    logic        evicted;
    logic        second_hit;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } access_outcome_t;

  // Shadow copy of the configuration registers.
  logic [2:0]  cfg_set_bits;
  logic [3:0]  cfg_ways;
  logic [5:0]  cfg_block_bits;

  // Shadow copy of the line store and the counters.
  logic        way_valid [0:LINES-1];
  logic [63:0] way_tag   [0:LINES-1];
  logic [31:0] way_stamp [0:LINES-1];
  logic [31:0] stamp_now;
  logic [31:0] hits_pred;
  logic [31:0] misses_pred;
  logic [31:0] evicts_pred;

  access_outcome_t pending_outcomes [$];
  int mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [31:0] sat_up(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Look one access up in the shadow store, fill or evict on a miss, and
  // return the outcome that the block should report for it.
  function automatic access_outcome_t lookup_and_fill(input logic [1:0] kind,
                                                      input logic [63:0] addr);
    access_outcome_t r;
    int sb;
    int nways;
    int base;
    int victim;
    logic [63:0] set_idx;
    logic [63:0] tag;
    logic found;
    logic have_free;
    r = '0;
    sb = (cfg_set_bits > SET_LIMIT) ? SET_LIMIT : int'(cfg_set_bits);
    nways = (cfg_ways == 0) ? 1 : int'(cfg_ways);
    if (nways > WAY_LIMIT) nways = WAY_LIMIT;
    stamp_now = stamp_now + 32'd1;
    if (kind != REQ_INSTR) begin
      r.accessed = 1'b1;
      // Shifts by the full width or more read as zero.
      set_idx = (addr >> int'(cfg_block_bits)) & ((64'd1 << sb) - 64'd1);
      tag = addr >> (int'(cfg_block_bits) + sb);
      base = int'(set_idx) * WAY_LIMIT;
      found = 1'b0;
      for (int w = 0; w < nways; w++) begin
        if (!found && way_valid[base + w] && way_tag[base + w] == tag) begin
          found = 1'b1;
          way_stamp[base + w] = stamp_now;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        hits_pred = sat_up(hits_pred);
      end else begin
        r.missed = 1'b1;
        misses_pred = sat_up(misses_pred);
        have_free = 1'b0;
        victim = 0;
        for (int w = 0; w < nways; w++) begin
          if (!have_free && !way_valid[base + w]) begin
            have_free = 1'b1;
            victim = w;
          end
        end
        // No free way: the oldest stamp goes, the lowest way on a tie.
        if (!have_free) begin
          for (int w = 1; w < nways; w++)
            if (way_stamp[base + w] < way_stamp[base + victim]) victim = w;
          r.evicted = 1'b1;
          evicts_pred = sat_up(evicts_pred);
        end
        way_valid[base + victim] = 1'b1;
        way_tag[base + victim] = tag;
        way_stamp[base + victim] = stamp_now;
      end
      if (kind == REQ_MODIFY) begin
        r.second_hit = 1'b1;
        hits_pred = sat_up(hits_pred);
      end
    end
    r.hits = hits_pred;
    r.misses = misses_pred;
    r.evictions = evicts_pred;
    return r;
  endfunction

  // Results are compared before a new request beat is predicted, since a
  // result in the same cycle always belongs to an earlier request.
  always @(posedge clk) begin
    access_outcome_t want;
    if (rst) begin
      cfg_set_bits = 3'd4;
      cfg_ways = 4'd1;
      cfg_block_bits = 6'd4;
      for (int i = 0; i < LINES; i++) begin
        way_valid[i] = 1'b0;
        way_tag[i] = '0;
        way_stamp[i] = '0;
      end
      stamp_now = '0;
      hits_pred = '0;
      misses_pred = '0;
      evicts_pred = '0;
      pending_outcomes.delete();
    end else begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result beat with none outstanding", 64'd1, 64'd0);
        end else begin
          want = pending_outcomes.pop_front();
          if (accessed !== want.accessed)
            report_mismatch("accessed", 64'(accessed), 64'(want.accessed));
          if (hit !== want.hit) report_mismatch("hit", 64'(hit), 64'(want.hit));
          if (missed !== want.missed)
            report_mismatch("missed", 64'(missed), 64'(want.missed));
          if (evicted !== want.evicted)
            report_mismatch("evicted", 64'(evicted), 64'(want.evicted));
          if (second_hit !== want.second_hit)
            report_mismatch("second_hit", 64'(second_hit), 64'(want.second_hit));
          if (hits_total !== want.hits)
            report_mismatch("hits_total", 64'(hits_total), 64'(want.hits));
          if (misses_total !== want.misses)
            report_mismatch("misses_total", 64'(misses_total), 64'(want.misses));
          if (evictions_total !== want.evictions)
            report_mismatch("evictions_total", 64'(evictions_total),
                            64'(want.evictions));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SET_BITS:   cfg_set_bits = pwdata[2:0];
          REG_WAYS:       cfg_ways = pwdata[3:0];
          REG_BLOCK_BITS: cfg_block_bits = pwdata[5:0];
          default: ;
        endcase
      end
      if (start && !busy) pending_outcomes.push_back(lookup_and_fill(req_type, address));
    end
    pending <= pending_outcomes.size();
  end

endmodule

// File: test/tb.sv
module tb;
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        start = 1'b0;
  logic [1:0]  req_type = REQ_INSTR;
  logic [63:0] address = '0;
  wire  [31:0] prdata;
  wire         pready;
  wire         busy;
  wire         done;
  wire         accessed;
  wire         hit;
  wire         missed;
  wire         evicted;
  wire         second_hit;
  wire  [31:0] hits_total;
  wire  [31:0] misses_total;
  wire  [31:0] evictions_total;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  logic        idling_on = 1'b1;

  // Settings as last written, used only to shape addresses.
  int cur_set_bits = 4;
  int cur_ways = 1;
  int cur_block_bits = 4;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_lru_cache_model uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .req_type(req_type), .address(address),
    .done(done), .accessed(accessed), .hit(hit), .missed(missed), .evicted(evicted),
    .second_hit(second_hit), .hits_total(hits_total), .misses_total(misses_total),
    .evictions_total(evictions_total)
  );

  salc_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .start(start), .busy(busy), .req_type(req_type), .address(address),
    .done(done), .accessed(accessed), .hit(hit), .missed(missed), .evicted(evicted),
    .second_hit(second_hit), .hits_total(hits_total), .misses_total(misses_total),
    .evictions_total(evictions_total),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: the run ends if no beat of any kind moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One APB write: setup phase, access phase, then back to idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request beat, hold it until taken, then perhaps leave a gap.
  task automatic issue(input logic [1:0] kind, input logic [63:0] addr);
    start <= 1'b1;
    req_type <= kind;
    address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Let every outstanding result come back before the settings change.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input int sb, input int nw, input int bb);
    write_reg(REG_SET_BITS, 32'(sb));
    write_reg(REG_WAYS, 32'(nw));
    write_reg(REG_BLOCK_BITS, 32'(bb));
    cur_set_bits = sb;
    cur_ways = nw;
    cur_block_bits = bb;
  endtask

  // Mostly small tags, often in sets 0 and 1, so that lines are reused and evicted;
  // now and then a fully random address.
  function automatic logic [63:0] pick_address();
    logic [63:0] noise;
    logic [63:0] tagv;
    logic [63:0] setv;
    int sb;
    int nw;
    noise = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return noise;
    sb = (cur_set_bits > 6) ? 6 : cur_set_bits;
    nw = (cur_ways == 0) ? 1 : ((cur_ways > 8) ? 8 : cur_ways);
    tagv = 64'($urandom_range(0, nw + 2));
    if ($urandom_range(0, 1) == 0)
      setv = 64'($urandom_range(0, (sb == 0) ? 0 : 1));
    else
      setv = 64'($urandom_range(0, (1 << sb) - 1));
    return (tagv << (cur_block_bits + sb)) | (setv << cur_block_bits) |
           (noise & ((64'd1 << cur_block_bits) - 64'd1));
  endfunction

  task automatic random_phase(input int sb, input int nw, input int bb, input int count);
    configure(sb, nw, bb);
    repeat (count) issue(2'($urandom_range(0, 3)), pick_address());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // The line store is cleared after reset with busy high.
    while (busy) @(posedge clk);

    // Directed part under the reset settings: one way, 16 sets, 16-byte lines.
    issue(REQ_INSTR, 64'h0);
    issue(REQ_LOAD, 64'h0);
    issue(REQ_LOAD, 64'h8);
    issue(REQ_STORE, 64'hF);
    issue(REQ_MODIFY, 64'h100);
    issue(REQ_MODIFY, 64'h100);
    issue(REQ_LOAD, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(REQ_LOAD, 64'h0);
    issue(REQ_INSTR, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(REQ_LOAD, 64'h8000_0000_0000_0000);
    issue(REQ_STORE, 64'h10);
    drain();

    // Two ways: old lines stay put, the free way fills, then LRU eviction.
    configure(4, 2, 4);
    issue(REQ_LOAD, 64'h0);
    issue(REQ_LOAD, 64'h8000_0000_0000_0000);
    issue(REQ_LOAD, 64'h200);
    issue(REQ_MODIFY, 64'h0);
    issue(REQ_STORE, 64'h8000_0000_0000_0000);
    drain();

    // Offset of 63 bits: only the top address bit reaches the set index, and every tag is 0.
    configure(6, 0, 63);
    issue(REQ_LOAD, 64'h1234_5678_9ABC_DEF0);
    issue(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(REQ_MODIFY, 64'h0);
    drain();

    // Random phases over a spread of settings, the extremes among them.
    random_phase(4, 1, 4, 200);
    random_phase(0, 8, 0, 250);
    random_phase(6, 8, 32, 200);
    random_phase(7, 15, 5, 200);
    random_phase(2, 0, 63, 120);
    random_phase(6, 4, 60, 150);
    random_phase(3, 2, 3, 250);
    // Final stretch runs back to back with no gaps.
    idling_on = 1'b0;
    random_phase(1, 5, 12, 460);

    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
